// ----- rtl/pgte_pkg.sv -----
`default_nettype none

package pgte_pkg;

   // grid size and derived address width
   localparam int NODE_COUNT = 4096;
   localparam int ADDR_W     = $clog2(NODE_COUNT);

   // index as it arrives, and widened far enough to hold NODE_COUNT itself
   localparam int INDEX_W    = 12;
   localparam int IDX_EXT_W  = 17;
   localparam logic [IDX_EXT_W-1:0] NODE_LIMIT = IDX_EXT_W'(NODE_COUNT);

   // fixed-point widths
   localparam int Q_W     = 32;   // Q16.16 inputs
   localparam int ACC_W   = 48;   // Q32.16 node and accumulator values
   localparam int FRAC_W  = 16;
   localparam int HI_W    = ACC_W - FRAC_W;  // integer half of a node value
   localparam int MA_W    = HI_W + 1;        // multiplier A operand
   localparam int PROD_W  = MA_W + Q_W;      // full lane product
   localparam int PHI_W   = 64;              // high-phase product kept
   localparam int PLO_W   = FRAC_W + 1 + Q_W; // low-phase product kept
   localparam int DELTA_W = 64;
   localparam int SUM_W   = 66;
   localparam int LANES   = 4;

   // operation codes
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_INTEG  = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_INTERP = 3'd4;
   localparam logic [2:0] OP_GRAD   = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_NODE     = 2'd0;
   localparam logic [1:0] KIND_VECTOR   = 2'd1;
   localparam logic [1:0] KIND_GRADIENT = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

   typedef logic signed [DELTA_W-1:0] delta_type;

   // sequencer strobes for the multiply lanes
   typedef struct packed {
      logic [2:0] op;
      logic       load_hi;
      logic       load_lo;
      logic       load_delta;
   } mac_ctrl_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > SUM_MAX) begin
         r = SUM_MAX[ACC_W-1:0];
      end else if (v < SUM_MIN) begin
         r = SUM_MIN[ACC_W-1:0];
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_acc(input logic signed [ACC_W-1:0] v);
      return {{(SUM_W-ACC_W){v[ACC_W-1]}}, v};
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_delta(input logic signed [DELTA_W-1:0] v);
      return {{(SUM_W-DELTA_W){v[DELTA_W-1]}}, v};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pgte_mac_unit.sv -----
`default_nettype none

module pgte_mac_unit (
   input  wire logic                               clock,
   input  wire pgte_pkg::mac_ctrl_type             ctrl,
   input  wire logic signed [pgte_pkg::ACC_W-1:0]  node_x,
   input  wire logic signed [pgte_pkg::ACC_W-1:0]  node_y,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    weight,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    grad_x,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    grad_y,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    value_a,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    value_b,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    value_c,
   input  wire logic signed [pgte_pkg::Q_W-1:0]    value_d,
   output pgte_pkg::delta_type                     delta_ff [pgte_pkg::LANES]
);

   logic                                  gather;
   logic signed [pgte_pkg::ACC_W-1:0]     lane_src [pgte_pkg::LANES];
   logic signed [pgte_pkg::Q_W-1:0]       lane_b   [pgte_pkg::LANES];
   logic signed [pgte_pkg::MA_W-1:0]      lane_a   [pgte_pkg::LANES];
   logic signed [pgte_pkg::PROD_W-1:0]    prod     [pgte_pkg::LANES];
   logic signed [pgte_pkg::PHI_W-1:0]     prod_hi_ff [pgte_pkg::LANES];
   logic signed [pgte_pkg::PLO_W-1:0]     prod_lo_ff [pgte_pkg::LANES];
   pgte_pkg::delta_type                   delta_in [pgte_pkg::LANES];
   logic signed [pgte_pkg::PHI_W-1:0]     sh_hi    [pgte_pkg::LANES];
   logic signed [pgte_pkg::PLO_W-1:0]     sh_lo    [pgte_pkg::LANES];

   assign gather = (ctrl.op == pgte_pkg::OP_INTERP) || (ctrl.op == pgte_pkg::OP_GRAD);

   // route operands to lanes
   always_comb begin
      for (int i = 0; i < pgte_pkg::LANES; i++) begin
         lane_src[i] = '0;
         lane_b[i]   = '0;
      end
      case (ctrl.op)
         pgte_pkg::OP_INTEG: begin
            lane_src[0] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_a[pgte_pkg::Q_W-1]}}, value_a};
            lane_b[0]   = weight;
            lane_src[1] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_b[pgte_pkg::Q_W-1]}}, value_b};
            lane_b[1]   = weight;
         end
         pgte_pkg::OP_DIV: begin
            lane_src[0] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_a[pgte_pkg::Q_W-1]}}, value_a};
            lane_b[0]   = grad_x;
            lane_src[1] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_c[pgte_pkg::Q_W-1]}}, value_c};
            lane_b[1]   = grad_y;
            lane_src[2] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_b[pgte_pkg::Q_W-1]}}, value_b};
            lane_b[2]   = grad_x;
            lane_src[3] = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_d[pgte_pkg::Q_W-1]}}, value_d};
            lane_b[3]   = grad_y;
         end
         pgte_pkg::OP_INTERP: begin
            lane_src[0] = node_x;
            lane_b[0]   = weight;
            lane_src[1] = node_y;
            lane_b[1]   = weight;
         end
         pgte_pkg::OP_GRAD: begin
            lane_src[0] = node_x;
            lane_b[0]   = grad_x;
            lane_src[1] = node_x;
            lane_b[1]   = grad_y;
            lane_src[2] = node_y;
            lane_b[2]   = grad_x;
            lane_src[3] = node_y;
            lane_b[3]   = grad_y;
         end
         default: begin
         end
      endcase
   end

   // high phase: whole 32-bit value for scatters, integer half for gathers;
   // low phase: unsigned fraction of the node value
   always_comb begin
      for (int i = 0; i < pgte_pkg::LANES; i++) begin
         if (ctrl.load_lo) begin
            lane_a[i] = {{(pgte_pkg::MA_W-pgte_pkg::FRAC_W){1'b0}},
                         lane_src[i][pgte_pkg::FRAC_W-1:0]};
         end else if (gather) begin
            lane_a[i] = {lane_src[i][pgte_pkg::ACC_W-1],
                         lane_src[i][pgte_pkg::ACC_W-1:pgte_pkg::FRAC_W]};
         end else begin
            lane_a[i] = {lane_src[i][pgte_pkg::Q_W-1], lane_src[i][pgte_pkg::Q_W-1:0]};
         end
         prod[i] = lane_a[i] * lane_b[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < pgte_pkg::LANES; i++) begin
         if (ctrl.load_hi) begin
            prod_hi_ff[i] <= prod[i][pgte_pkg::PHI_W-1:0];
         end
         if (ctrl.load_lo) begin
            prod_lo_ff[i] <= prod[i][pgte_pkg::PLO_W-1:0];
         end
         if (ctrl.load_delta) begin
            delta_ff[i] <= delta_in[i];
         end
      end
   end

   // combine partial products into one term per lane
   always_comb begin
      for (int i = 0; i < pgte_pkg::LANES; i++) begin
         sh_hi[i]    = prod_hi_ff[i] >>> pgte_pkg::FRAC_W;
         sh_lo[i]    = prod_lo_ff[i] >>> pgte_pkg::FRAC_W;
         delta_in[i] = '0;
      end
      case (ctrl.op)
         pgte_pkg::OP_INTEG: begin
            delta_in[0] = sh_hi[0];
            delta_in[1] = sh_hi[1];
         end
         pgte_pkg::OP_DIV: begin
            delta_in[0] = sh_hi[0] + sh_hi[1];
            delta_in[1] = sh_hi[2] + sh_hi[3];
         end
         pgte_pkg::OP_INTERP, pgte_pkg::OP_GRAD: begin
            for (int i = 0; i < pgte_pkg::LANES; i++) begin
               delta_in[i] = prod_hi_ff[i] +
                  {{(pgte_pkg::DELTA_W-pgte_pkg::PLO_W){sh_lo[i][pgte_pkg::PLO_W-1]}}, sh_lo[i]};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/particle_grid_transfer_engine.sv -----
// A word passes the node-memory read, two multiply phases (integer and fraction halves of the
//   node value), a term sum and the write-back before the next is taken; a read or final gather
//   word is emitted from the write-back, which holds while an earlier result still waits.
// Reset (synchronous, active high) idles the sequencer, empties the output register and
//   clears the four gather accumulators; node memory contents are kept and undefined at start.
`default_nettype none

module particle_grid_transfer_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [2:0]                           req_operation,
   input  wire logic [pgte_pkg::INDEX_W-1:0]         req_node_index,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_weight,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_grad_x,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_grad_y,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_value_a,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_value_b,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_value_c,
   input  wire logic signed [pgte_pkg::Q_W-1:0]      req_value_d,
   input  wire logic                                 req_last_portion,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic [1:0]                           rsp_result_kind,
   output      logic signed [pgte_pkg::ACC_W-1:0]    rsp_result_a,
   output      logic signed [pgte_pkg::ACC_W-1:0]    rsp_result_b,
   output      logic signed [pgte_pkg::ACC_W-1:0]    rsp_result_c,
   output      logic signed [pgte_pkg::ACC_W-1:0]    rsp_result_d
);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // wait for a word
   localparam logic [2:0] S_READ   = 3'd1;  // node memory data arrives
   localparam logic [2:0] S_MUL_HI = 3'd2;  // first multiply phase
   localparam logic [2:0] S_MUL_LO = 3'd3;  // fraction phase for gathers
   localparam logic [2:0] S_TERM   = 3'd4;  // add partial products
   localparam logic [2:0] S_UPDATE = 3'd5;  // write back, accumulate, emit

   logic [2:0]                          state_ff, state_in;
   logic                                accept;

   // node memory, one array per component, one read and one write port each
   logic signed [pgte_pkg::ACC_W-1:0]   node_x_mem [pgte_pkg::NODE_COUNT];
   logic signed [pgte_pkg::ACC_W-1:0]   node_y_mem [pgte_pkg::NODE_COUNT];
   logic signed [pgte_pkg::ACC_W-1:0]   rd_x_ff, rd_y_ff;
   logic [pgte_pkg::IDX_EXT_W-1:0]      idx_ext;
   logic [pgte_pkg::ADDR_W-1:0]         rd_addr;
   logic                                mem_we;

   // held word
   logic [2:0]                          op_ff;
   logic [pgte_pkg::ADDR_W-1:0]         addr_ff;
   logic                                node_ok_ff;
   logic                                last_ff;
   logic signed [pgte_pkg::Q_W-1:0]     weight_ff, grad_x_ff, grad_y_ff;
   logic signed [pgte_pkg::Q_W-1:0]     value_a_ff, value_b_ff, value_c_ff, value_d_ff;
   logic signed [pgte_pkg::ACC_W-1:0]   node_x_ff, node_y_ff;

   // datapath
   pgte_pkg::mac_ctrl_type              mac_ctrl;
   pgte_pkg::delta_type                 delta [pgte_pkg::LANES];
   logic signed [pgte_pkg::ACC_W-1:0]   acc_ff [pgte_pkg::LANES];
   logic signed [pgte_pkg::ACC_W-1:0]   acc_sum [pgte_pkg::LANES];
   logic signed [pgte_pkg::ACC_W-1:0]   node_x_in, node_y_in;
   logic                                gather, scatter, emit, stall, upd_go;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_kind_ff, rsp_kind_in;
   logic signed [pgte_pkg::ACC_W-1:0]   rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;
   logic signed [pgte_pkg::ACC_W-1:0]   rsp_a_in, rsp_b_in, rsp_c_in, rsp_d_in;

   // Take one word at a time; the whole sequence runs before the next is taken,
   // so a node written back is never read by an overlapping word.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign idx_ext = {{(pgte_pkg::IDX_EXT_W-pgte_pkg::INDEX_W){1'b0}}, req_node_index};
   assign rd_addr = idx_ext[pgte_pkg::ADDR_W-1:0];

   assign gather  = (op_ff == pgte_pkg::OP_INTERP) || (op_ff == pgte_pkg::OP_GRAD);
   assign scatter = (op_ff == pgte_pkg::OP_WRITE) || (op_ff == pgte_pkg::OP_INTEG) ||
                    (op_ff == pgte_pkg::OP_DIV);
   assign emit    = (op_ff == pgte_pkg::OP_READ) || (gather && last_ff);

   // hold an emitting update while a previous result still waits
   assign stall   = emit && rsp_valid_ff && !rsp_ready;
   assign upd_go  = (state_ff == S_UPDATE) && !stall;
   assign mem_we  = upd_go && scatter && node_ok_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_READ;
         S_READ:   state_in = S_MUL_HI;
         S_MUL_HI: state_in = S_MUL_LO;
         S_MUL_LO: state_in = S_TERM;
         S_TERM:   state_in = S_UPDATE;
         S_UPDATE: if (upd_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // read every cycle at the incoming index; the data is used right after accept
   always_ff @(posedge clock) begin
      rd_x_ff <= node_x_mem[rd_addr];
      rd_y_ff <= node_y_mem[rd_addr];
      if (mem_we) begin
         node_x_mem[addr_ff] <= node_x_in;
         node_y_mem[addr_ff] <= node_y_in;
      end
   end

   // capture the word; an index past the grid reads as zero
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_operation;
         addr_ff    <= rd_addr;
         node_ok_ff <= (idx_ext < pgte_pkg::NODE_LIMIT);
         last_ff    <= req_last_portion;
         weight_ff  <= req_weight;
         grad_x_ff  <= req_grad_x;
         grad_y_ff  <= req_grad_y;
         value_a_ff <= req_value_a;
         value_b_ff <= req_value_b;
         value_c_ff <= req_value_c;
         value_d_ff <= req_value_d;
      end
      if (state_ff == S_READ) begin
         node_x_ff <= node_ok_ff ? rd_x_ff : '0;
         node_y_ff <= node_ok_ff ? rd_y_ff : '0;
      end
   end

   assign mac_ctrl.op         = op_ff;
   assign mac_ctrl.load_hi    = (state_ff == S_MUL_HI);
   assign mac_ctrl.load_lo    = (state_ff == S_MUL_LO);
   assign mac_ctrl.load_delta = (state_ff == S_TERM);

   pgte_mac_unit u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .node_x   (node_x_ff),
      .node_y   (node_y_ff),
      .weight   (weight_ff),
      .grad_x   (grad_x_ff),
      .grad_y   (grad_y_ff),
      .value_a  (value_a_ff),
      .value_b  (value_b_ff),
      .value_c  (value_c_ff),
      .value_d  (value_d_ff),
      .delta_ff (delta)
   );

   // saturating accumulate; lanes a gather does not use carry a zero term
   always_comb begin
      for (int i = 0; i < pgte_pkg::LANES; i++) begin
         acc_sum[i] = pgte_pkg::sat_acc(pgte_pkg::ext_acc(acc_ff[i]) +
                                        pgte_pkg::ext_delta(delta[i]));
      end
   end

   // node write-back value
   always_comb begin
      case (op_ff)
         pgte_pkg::OP_WRITE: begin
            node_x_in = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_a_ff[pgte_pkg::Q_W-1]}},
                         value_a_ff};
            node_y_in = {{(pgte_pkg::ACC_W-pgte_pkg::Q_W){value_b_ff[pgte_pkg::Q_W-1]}},
                         value_b_ff};
         end
         pgte_pkg::OP_INTEG: begin
            node_x_in = pgte_pkg::sat_acc(pgte_pkg::ext_acc(node_x_ff) +
                                          pgte_pkg::ext_delta(delta[0]));
            node_y_in = pgte_pkg::sat_acc(pgte_pkg::ext_acc(node_y_ff) +
                                          pgte_pkg::ext_delta(delta[1]));
         end
         pgte_pkg::OP_DIV: begin
            node_x_in = pgte_pkg::sat_acc(pgte_pkg::ext_acc(node_x_ff) -
                                          pgte_pkg::ext_delta(delta[0]));
            node_y_in = pgte_pkg::sat_acc(pgte_pkg::ext_acc(node_y_ff) -
                                          pgte_pkg::ext_delta(delta[1]));
         end
         default: begin
            node_x_in = node_x_ff;
            node_y_in = node_y_ff;
         end
      endcase
   end

   // gather accumulators: add on every gather, clear after an emit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pgte_pkg::LANES; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (upd_go && gather) begin
         for (int i = 0; i < pgte_pkg::LANES; i++) begin
            acc_ff[i] <= last_ff ? '0 : acc_sum[i];
         end
      end
   end

   // result word
   always_comb begin
      rsp_kind_in = pgte_pkg::KIND_NODE;
      rsp_a_in    = acc_sum[0];
      rsp_b_in    = acc_sum[1];
      rsp_c_in    = '0;
      rsp_d_in    = '0;
      case (op_ff)
         pgte_pkg::OP_READ: begin
            rsp_kind_in = pgte_pkg::KIND_NODE;
            rsp_a_in    = node_x_ff;
            rsp_b_in    = node_y_ff;
         end
         pgte_pkg::OP_INTERP: begin
            rsp_kind_in = pgte_pkg::KIND_VECTOR;
         end
         pgte_pkg::OP_GRAD: begin
            rsp_kind_in = pgte_pkg::KIND_GRADIENT;
            rsp_c_in    = acc_sum[2];
            rsp_d_in    = acc_sum[3];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (upd_go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (upd_go && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_a_ff    <= rsp_a_in;
         rsp_b_ff    <= rsp_b_in;
         rsp_c_ff    <= rsp_c_in;
         rsp_d_ff    <= rsp_d_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_a    = rsp_a_ff;
   assign rsp_result_b    = rsp_b_ff;
   assign rsp_result_c    = rsp_c_ff;
   assign rsp_result_d    = rsp_d_ff;

`ifndef SYNTHESIS
   // an accepted word always starts with the memory read
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ))
      else $error("accepted word did not start with a node read");

   // a new result appears only out of the update step
   a_emit_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_UPDATE))
      else $error("result raised outside the update step");

   // node memory is written only by the update step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_UPDATE))
      else $error("node write outside the update step");

   // a final gather leaves all accumulators clear
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (upd_go && gather && last_ff) |=>
         (acc_ff[0] == '0) && (acc_ff[1] == '0) && (acc_ff[2] == '0) && (acc_ff[3] == '0))
      else $error("accumulators not cleared after final gather");

   // a stalled update must not let the output register drop its word
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (stall && (state_ff == S_UPDATE)) |=> rsp_valid_ff && (state_ff == S_UPDATE))
      else $error("update advanced while result was stalled");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

   // Spare operation codes: the engine must drop these words without a trace.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Handy Q16.16 and Q32.16 corner values.
   localparam logic signed [pgte_pkg::Q_W-1:0]   Q_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [pgte_pkg::Q_W-1:0]   Q_MIN   = 32'sh8000_0000;
   localparam logic signed [pgte_pkg::Q_W-1:0]   Q_ONE   = 32'sh0001_0000;
   localparam logic signed [pgte_pkg::Q_W-1:0]   Q_HALF  = 32'sh0000_8000;
   localparam logic signed [pgte_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(pgte_pkg::ACC_W-1){1'b1}}};
   localparam logic signed [pgte_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(pgte_pkg::ACC_W-1){1'b0}}};

   localparam int RANDOM_WORDS  = 1290;    // non-ignored words, directed part included
   localparam int MID_DRAIN_AT  = 700;     // sender pauses here until all replies are in
   localparam int HOLD_AT_REPLY = 120;     // receiver starts its long hold-off here
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   // Wide enough for a 48 x 32 bit product plus a few bits of headroom.
   typedef logic signed [81:0] wide_type;
   typedef logic [pgte_pkg::INDEX_W-1:0] index_type;

   typedef struct {
      logic [2:0]                      op;
      logic [pgte_pkg::INDEX_W-1:0]    idx;
      logic signed [pgte_pkg::Q_W-1:0] w;
      logic signed [pgte_pkg::Q_W-1:0] gx;
      logic signed [pgte_pkg::Q_W-1:0] gy;
      logic signed [pgte_pkg::Q_W-1:0] va;
      logic signed [pgte_pkg::Q_W-1:0] vb;
      logic signed [pgte_pkg::Q_W-1:0] vc;
      logic signed [pgte_pkg::Q_W-1:0] vd;
      logic                            last;
   } grid_word_type;

   typedef struct {
      logic [1:0]                        kind;
      logic signed [pgte_pkg::ACC_W-1:0] a;
      logic signed [pgte_pkg::ACC_W-1:0] b;
      logic signed [pgte_pkg::ACC_W-1:0] c;
      logic signed [pgte_pkg::ACC_W-1:0] d;
   } node_reply_type;

   typedef struct {
      grid_word_type  wd;
      bit             known;   // reply below is typed in rather than predicted
      node_reply_type want;
   } stim_row_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and the DUT
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   logic [2:0]                        req_operation    = '0;
   logic [pgte_pkg::INDEX_W-1:0]      req_node_index   = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_weight       = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_grad_x       = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_grad_y       = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_value_a      = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_value_b      = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_value_c      = '0;
   logic signed [pgte_pkg::Q_W-1:0]   req_value_d      = '0;
   logic                              req_last_portion = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   logic [1:0]                        rsp_result_kind;
   logic signed [pgte_pkg::ACC_W-1:0] rsp_result_a;
   logic signed [pgte_pkg::ACC_W-1:0] rsp_result_b;
   logic signed [pgte_pkg::ACC_W-1:0] rsp_result_c;
   logic signed [pgte_pkg::ACC_W-1:0] rsp_result_d;

   particle_grid_transfer_engine dut (.*);

   // ---------------------------------------------------------------------------
   // Grid predictor: shadow node store, gather sums and the replies still due
   // ---------------------------------------------------------------------------
   logic signed [pgte_pkg::ACC_W-1:0] grid_x [pgte_pkg::NODE_COUNT];
   logic signed [pgte_pkg::ACC_W-1:0] grid_y [pgte_pkg::NODE_COUNT];
   logic signed [pgte_pkg::ACC_W-1:0] gather_sum [pgte_pkg::LANES];
   bit                                node_seen [pgte_pkg::NODE_COUNT];
   logic [pgte_pkg::INDEX_W-1:0]      seen_list [$];
   node_reply_type                    due_replies [$];

   int  failures     = 0;
   int  words_sent   = 0;
   int  useful_sent  = 0;
   bit  send_burst   = 1'b0;
   bit  drain_next   = 1'b0;
   bit  rsp_hold     = 1'b0;

   function automatic node_reply_type reply(logic [1:0] kind,
                                            logic signed [pgte_pkg::ACC_W-1:0] a,
                                            logic signed [pgte_pkg::ACC_W-1:0] b,
                                            logic signed [pgte_pkg::ACC_W-1:0] c,
                                            logic signed [pgte_pkg::ACC_W-1:0] d);
      node_reply_type r;
      r.kind = kind;
      r.a    = a;
      r.b    = b;
      r.c    = c;
      r.d    = d;
      return r;
   endfunction

   function automatic grid_word_type contribution(logic [2:0] op,
                                                  logic [pgte_pkg::INDEX_W-1:0] idx,
                                                  logic signed [pgte_pkg::Q_W-1:0] w,
                                                  logic signed [pgte_pkg::Q_W-1:0] gx,
                                                  logic signed [pgte_pkg::Q_W-1:0] gy,
                                                  logic signed [pgte_pkg::Q_W-1:0] va,
                                                  logic signed [pgte_pkg::Q_W-1:0] vb,
                                                  logic signed [pgte_pkg::Q_W-1:0] vc,
                                                  logic signed [pgte_pkg::Q_W-1:0] vd,
                                                  logic last);
      grid_word_type g;
      g.op   = op;
      g.idx  = idx;
      g.w    = w;
      g.gx   = gx;
      g.gy   = gy;
      g.va   = va;
      g.vb   = vb;
      g.vc   = vc;
      g.vd   = vd;
      g.last = last;
      return g;
   endfunction

   // Exact product, then an arithmetic shift: rounds toward minus infinity.
   function automatic wide_type fixed_product(wide_type a, wide_type b);
      wide_type p;
      p = a * b;
      return p >>> pgte_pkg::FRAC_W;
   endfunction

   function automatic logic signed [pgte_pkg::ACC_W-1:0] clip48(wide_type v);
      if (v > ACC_MAX) begin
         return ACC_MAX;
      end else if (v < ACC_MIN) begin
         return ACC_MIN;
      end
      return v[pgte_pkg::ACC_W-1:0];
   endfunction

   // Apply one accepted word to the shadow state; return 1 with the reply it emits.
   function automatic bit predict_grid(grid_word_type wd, output node_reply_type res);
      logic signed [pgte_pkg::ACC_W-1:0] nx;
      logic signed [pgte_pkg::ACC_W-1:0] ny;
      bit                                emit;
      nx   = grid_x[wd.idx];
      ny   = grid_y[wd.idx];
      emit = 1'b0;
      res  = reply(pgte_pkg::KIND_NODE, 0, 0, 0, 0);
      case (wd.op)
         pgte_pkg::OP_WRITE: begin
            grid_x[wd.idx] = wd.va;
            grid_y[wd.idx] = wd.vb;
            if (!node_seen[wd.idx]) begin
               node_seen[wd.idx] = 1'b1;
               seen_list.push_back(wd.idx);
            end
         end
         pgte_pkg::OP_READ: begin
            res  = reply(pgte_pkg::KIND_NODE, nx, ny, 0, 0);
            emit = 1'b1;
         end
         pgte_pkg::OP_INTEG: begin
            grid_x[wd.idx] = clip48(nx + fixed_product(wd.va, wd.w));
            grid_y[wd.idx] = clip48(ny + fixed_product(wd.vb, wd.w));
         end
         pgte_pkg::OP_DIV: begin
            grid_x[wd.idx] = clip48(nx - (fixed_product(wd.va, wd.gx) +
                                          fixed_product(wd.vc, wd.gy)));
            grid_y[wd.idx] = clip48(ny - (fixed_product(wd.vb, wd.gx) +
                                          fixed_product(wd.vd, wd.gy)));
         end
         pgte_pkg::OP_INTERP: begin
            gather_sum[0] = clip48(gather_sum[0] + fixed_product(nx, wd.w));
            gather_sum[1] = clip48(gather_sum[1] + fixed_product(ny, wd.w));
            if (wd.last) begin
               res  = reply(pgte_pkg::KIND_VECTOR, gather_sum[0], gather_sum[1], 0, 0);
               emit = 1'b1;
            end
         end
         pgte_pkg::OP_GRAD: begin
            gather_sum[0] = clip48(gather_sum[0] + fixed_product(nx, wd.gx));
            gather_sum[1] = clip48(gather_sum[1] + fixed_product(nx, wd.gy));
            gather_sum[2] = clip48(gather_sum[2] + fixed_product(ny, wd.gx));
            gather_sum[3] = clip48(gather_sum[3] + fixed_product(ny, wd.gy));
            if (wd.last) begin
               res  = reply(pgte_pkg::KIND_GRADIENT, gather_sum[0], gather_sum[1],
                            gather_sum[2], gather_sum[3]);
               emit = 1'b1;
            end
         end
         default: ;
      endcase
      // Any emit clears all four sums, whichever gather raised it.
      if (emit && wd.op != pgte_pkg::OP_READ) begin
         foreach (gather_sum[i]) gather_sum[i] = '0;
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------------------
   // Half small magnitudes so sums stay in range, the rest full-range values and corners.
   function automatic logic signed [pgte_pkg::Q_W-1:0] rand_q();
      int unsigned                     pick;
      logic signed [pgte_pkg::Q_W-1:0] v;
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         v = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF;
      end else if (pick < 17) begin
         v = $urandom();
      end else begin
         case ($urandom_range(0, 4))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = '0;
            3:       v = -1;
            default: v = Q_ONE;
         endcase
      end
      return v;
   endfunction

   function automatic grid_word_type random_word();
      return contribution(3'($urandom_range(0, 7)),
                          index_type'($urandom_range(0, pgte_pkg::NODE_COUNT - 1)),
                          rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                          rand_q(), rand_q(), 1'($urandom_range(0, 1)));
   endfunction

   // Only nodes written since reset may be read, scattered into or gathered from.
   function automatic logic [pgte_pkg::INDEX_W-1:0] pick_node();
      return seen_list[$urandom_range(0, seen_list.size() - 1)];
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: idle, offer one word, hold it until taken, then predict its reply
   // ---------------------------------------------------------------------------
   task automatic send_word(grid_word_type wd, bit known, node_reply_type want);
      int              gap;
      bit              emits;
      node_reply_type  got;
      if (words_sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      gap = (send_burst || rsp_hold) ? 0 : $urandom_range(0, 12);
      if (drain_next) begin
         // Pause until every reply owed so far has come back.
         drain_next = 1'b0;
         req_valid <= 1'b0;
         do @(posedge clock); while (due_replies.size() != 0);
      end else if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= wd.op;
      req_node_index   <= wd.idx;
      req_weight       <= wd.w;
      req_grad_x       <= wd.gx;
      req_grad_y       <= wd.gy;
      req_value_a      <= wd.va;
      req_value_b      <= wd.vb;
      req_value_c      <= wd.vc;
      req_value_d      <= wd.vd;
      req_last_portion <= wd.last;
      do @(posedge clock); while (!req_ready);
      emits = predict_grid(wd, got);
      if (emits) due_replies.push_back(known ? want : got);
      words_sent++;
      if (wd.op <= pgte_pkg::OP_GRAD) begin
         useful_sent++;
         if (useful_sent == MID_DRAIN_AT) drain_next = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Reply checker: compare each taken word with the oldest reply due
   // ---------------------------------------------------------------------------
   function automatic void match_field(string name,
                                       logic signed [pgte_pkg::ACC_W-1:0] want,
                                       logic signed [pgte_pkg::ACC_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      node_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_replies.size() == 0) begin
            failures++;
            $display("%0t reply with nothing due: kind %0d, expected none, actual %h %h",
                     $time, rsp_result_kind, rsp_result_a, rsp_result_b);
         end else begin
            want = due_replies.pop_front();
            match_field("result_kind", want.kind, rsp_result_kind);
            match_field("result_a", want.a, rsp_result_a);
            match_field("result_b", want.b, rsp_result_b);
            match_field("result_c", want.c, rsp_result_c);
            match_field("result_d", want.d, rsp_result_d);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall a random count after each word; once, hold off long enough
   // for the engine to back up and drop req_ready
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      int taken;
      bit burst;
      taken = 0;
      burst = 1'b0;
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
         if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         if (taken == HOLD_AT_REPLY) begin
            rsp_hold = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
            rsp_hold = 1'b0;
         end else begin
            stall = burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: abort a hung run
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus: directed table, then random particle traffic
   // ---------------------------------------------------------------------------
   initial begin
      stim_row_type   directed_rows [$];
      node_reply_type no_reply;
      grid_word_type  wd;
      int             sel;
      int             len;
      logic [2:0]     gop;

      foreach (gather_sum[i]) gather_sum[i] = '0;
      no_reply = reply(pgte_pkg::KIND_NODE, 0, 0, 0, 0);

      // Corner writes at both ends of the index range, read straight back.
      directed_rows.push_back('{contribution(pgte_pkg::OP_WRITE, 12'h000, 0, 0, 0,
                                             Q_MAX, Q_MIN, 0, 0, 1'b0), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'h000, 0, 0, 0,
                                             0, 0, 0, 0, 1'b0), 1'b1,
                                reply(pgte_pkg::KIND_NODE, Q_MAX, Q_MIN, 0, 0)});
      directed_rows.push_back('{contribution(pgte_pkg::OP_WRITE, 12'hFFF, 0, 0, 0,
                                             -1, 1, 0, 0, 1'b0), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'hFFF, 0, 0, 0,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_NODE, -1, 1, 0, 0)});
      // Drive node 0 into saturation from both sides with full-scale integrates.
      repeat (3) begin
         directed_rows.push_back('{contribution(pgte_pkg::OP_INTEG, 12'h000, Q_MAX, 0, 0,
                                                Q_MAX, Q_MIN, 0, 0, 1'b0), 1'b0, no_reply});
      end
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'h000, 0, 0, 0,
                                             0, 0, 0, 0, 1'b0), 1'b1,
                                reply(pgte_pkg::KIND_NODE, ACC_MAX, ACC_MIN, 0, 0)});
      // Unit-weight interpolate passes the saturated node through unchanged.
      directed_rows.push_back('{contribution(pgte_pkg::OP_INTERP, 12'h000, Q_ONE, 0, 0,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_VECTOR, ACC_MAX, ACC_MIN, 0, 0)});
      directed_rows.push_back('{contribution(pgte_pkg::OP_GRAD, 12'hFFF, 0, Q_ONE, 0,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_GRADIENT, -1, 0, 1, 0)});
      // Tiny gradients: the shift rounds toward minus infinity.
      directed_rows.push_back('{contribution(pgte_pkg::OP_GRAD, 12'hFFF, 0, 1, -1,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_GRADIENT, -1, 0, 0, -1)});
      // Mixed gathers: a saturating gradient, closed by an interpolate emit.
      directed_rows.push_back('{contribution(pgte_pkg::OP_GRAD, 12'h000, 0, Q_MAX, Q_MIN,
                                             0, 0, 0, 0, 1'b0), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_INTERP, 12'hFFF, Q_ONE, 0, 0,
                                             0, 0, 0, 0, 1'b1), 1'b0, no_reply});
      // Lanes c and d must have been cleared by that interpolate emit.
      directed_rows.push_back('{contribution(pgte_pkg::OP_GRAD, 12'hFFF, 0, Q_ONE, 0,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_GRADIENT, -1, 0, 1, 0)});
      // Full-scale divergence: the huge terms add rather than cancel; x saturates, y nears the top.
      directed_rows.push_back('{contribution(pgte_pkg::OP_DIV, 12'hFFF, 0, Q_MIN, Q_MIN,
                                             Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0),
                                1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'hFFF, 0, 0, 0,
                                             0, 0, 0, 0, 1'b0), 1'b0, no_reply});
      // Spare codes are dropped, even with last set.
      directed_rows.push_back('{contribution(OP_SPARE_6, 12'h000, Q_MAX, Q_MIN, Q_MAX,
                                             -1, -1, -1, -1, 1'b1), 1'b0, no_reply});
      directed_rows.push_back('{contribution(OP_SPARE_7, 12'hFFF, Q_MIN, Q_MAX, Q_MIN,
                                             1, 1, 1, 1, 1'b1), 1'b0, no_reply});
      // last on a scatter means nothing; scalar integrate keeps y.
      directed_rows.push_back('{contribution(pgte_pkg::OP_WRITE, 12'hA5A, 0, 0, 0,
                                             Q_ONE, -Q_ONE, 0, 0, 1'b1), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_INTEG, 12'hA5A, Q_HALF, 0, 0,
                                             3, 0, 0, 0, 1'b1), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'hA5A, 0, 0, 0,
                                             0, 0, 0, 0, 1'b0), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_INTERP, 12'hA5A, -Q_HALF, 0, 0,
                                             0, 0, 0, 0, 1'b1), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_WRITE, 12'h5A5, 0, 0, 0,
                                             0, -1, 0, 0, 1'b0), 1'b0, no_reply});
      directed_rows.push_back('{contribution(pgte_pkg::OP_READ, 12'h5A5, 0, 0, 0,
                                             0, 0, 0, 0, 1'b1), 1'b1,
                                reply(pgte_pkg::KIND_NODE, 0, -1, 0, 0)});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].wd, directed_rows[i].known, directed_rows[i].want);
      end

      // Settle before the random part starts.
      drain_next = 1'b1;
      while (useful_sent < RANDOM_WORDS) begin
         sel = $urandom_range(0, 99);
         wd  = random_word();
         if (sel < 18) begin
            // Write: half fresh nodes, half overwrites.
            wd.op  = pgte_pkg::OP_WRITE;
            wd.idx = $urandom_range(0, 1) ?
                     index_type'($urandom_range(0, pgte_pkg::NODE_COUNT - 1)) : pick_node();
            send_word(wd, 1'b0, no_reply);
         end else if (sel < 53) begin
            // Read or scatter into a live node.
            wd.idx = pick_node();
            if (sel < 28) begin
               wd.op = pgte_pkg::OP_READ;
            end else if (sel < 43) begin
               wd.op = pgte_pkg::OP_INTEG;
               if ($urandom_range(0, 3) == 0) wd.vb = '0;
            end else begin
               wd.op = pgte_pkg::OP_DIV;
            end
            send_word(wd, 1'b0, no_reply);
         end else if (sel < 93) begin
            // One particle: a run of gathers closed by last; now and then a stray
            // op of the other kind, and now and then no close at all.
            len = $urandom_range(1, 4);
            gop = $urandom_range(0, 1) ? pgte_pkg::OP_INTERP : pgte_pkg::OP_GRAD;
            for (int k = 0; k < len; k++) begin
               wd      = random_word();
               wd.idx  = pick_node();
               wd.op   = ($urandom_range(0, 9) == 0) ?
                         ((gop == pgte_pkg::OP_GRAD) ? pgte_pkg::OP_INTERP : pgte_pkg::OP_GRAD)
                         : gop;
               wd.last = (k == len - 1) && ($urandom_range(0, 9) != 0);
               send_word(wd, 1'b0, no_reply);
            end
         end else begin
            // Noise on a spare code, any index.
            wd.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            send_word(wd, 1'b0, no_reply);
         end
      end

      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      // Give a late, unexpected reply time to show up.
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
